FILE: rtl/rcx_pkg.sv
package rcx_pkg;

    localparam int unsigned CHAR_W            = 8;
    localparam int unsigned MAX_DOT_CHARS_DEF = 62;
    localparam int unsigned RANGE_MAX_CHARS   = 26;

    localparam logic [CHAR_W-1:0] DOT_FIRST_RESET = 8'd32;
    localparam logic [CHAR_W-1:0] DOT_END_RESET   = 8'd93;

    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;

    typedef enum logic [0:0] {
        CFG_DOT_FIRST = 1'b0,
        CFG_DOT_END   = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        MODE_OUT      = 4'd0,
        MODE_CLASS    = 4'd1,
        MODE_UP_START = 4'd2,
        MODE_UP_DASH  = 4'd3,
        MODE_LO_START = 4'd4,
        MODE_LO_DASH  = 4'd5,
        MODE_DG_START = 4'd6,
        MODE_DG_DASH  = 4'd7,
        MODE_ESC      = 4'd8
    } scan_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE0,
        ST_PRE1,
        ST_RUN,
        ST_POST
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_PRE0,
        SEL_PRE1,
        SEL_RUN,
        SEL_POST
    } emit_sel_t;

    typedef struct packed {
        logic pre0;
        logic pre1;
        logic run;
        logic post;
    } plan_flags_t;

    typedef struct packed {
        logic      in_ready;
        logic      accept;
        logic      load_out;
        emit_sel_t sel;
        logic      last;
        logic      run_step;
    } rcx_cmd_t;

    typedef struct packed {
        plan_flags_t dec;
        plan_flags_t plan;
        logic        run_last;
        logic        run_nz;
        logic        out_free;
    } rcx_sts_t;

endpackage

FILE: rtl/rcx_if.sv
interface rcx_in_if
    import rcx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              is_final;

    modport source (output valid, output in_char, output is_final, input ready);
    modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

interface rcx_out_if
    import rcx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              run_done;
    logic              pattern_done;

    modport source (output valid, output out_char, output run_done, output pattern_done,
                    input ready);
    modport sink   (input valid, input out_char, input run_done, input pattern_done,
                    output ready);
endinterface

FILE: rtl/rcx_ctrl.sv
module rcx_ctrl
    import rcx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  rcx_sts_t sts,
    output rcx_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t after_cur;

    function automatic ctrl_state_t next_after(ctrl_state_t s, plan_flags_t f);
        ctrl_state_t r;
        r = ST_IDLE;
        case (s)
            ST_IDLE: r = f.pre0 ? ST_PRE0 : f.pre1 ? ST_PRE1 : f.run ? ST_RUN :
                         f.post ? ST_POST : ST_IDLE;
            ST_PRE0: r = f.pre1 ? ST_PRE1 : f.run ? ST_RUN : f.post ? ST_POST : ST_IDLE;
            ST_PRE1: r = f.run ? ST_RUN : f.post ? ST_POST : ST_IDLE;
            ST_RUN:  r = f.post ? ST_POST : ST_IDLE;
            default: r = ST_IDLE;
        endcase
        return r;
    endfunction

    assign after_cur = next_after(state_reg, sts.plan);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = next_after(ST_IDLE, sts.dec);
                end
            end
            ST_PRE0, ST_PRE1, ST_POST:
            begin
                if (sts.out_free)
                begin
                    state_next = after_cur;
                end
            end
            ST_RUN:
            begin
                if (sts.out_free && sts.run_last)
                begin
                    state_next = after_cur;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = SEL_POST;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = in_valid;
            end
            ST_PRE0:
            begin
                cmd.load_out = sts.out_free;
                cmd.sel      = SEL_PRE0;
                cmd.last     = (after_cur == ST_IDLE);
            end
            ST_PRE1:
            begin
                cmd.load_out = sts.out_free;
                cmd.sel      = SEL_PRE1;
                cmd.last     = (after_cur == ST_IDLE);
            end
            ST_RUN:
            begin
                cmd.load_out = sts.out_free;
                cmd.sel      = SEL_RUN;
                cmd.last     = sts.run_last && (after_cur == ST_IDLE);
                cmd.run_step = sts.out_free;
            end
            ST_POST:
            begin
                cmd.load_out = sts.out_free;
                cmd.sel      = SEL_POST;
                cmd.last     = 1'b1;
            end
            default: cmd.in_ready = 1'b0;
        endcase
    end

    a_run_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> sts.run_nz)
        else $error("run phase entered with empty count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten before transfer");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (sts.dec != '0)) |=> !cmd.in_ready)
        else $error("new character taken while results pending");

endmodule

FILE: rtl/rcx_datapath.sv
module rcx_datapath
    import rcx_pkg::*;
#(
    parameter int unsigned MAX_DOT_CHARS = MAX_DOT_CHARS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              is_final,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CHAR_W-1:0] cfg_data,
    input  rcx_cmd_t          cmd,
    output rcx_sts_t          sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              run_done,
    output logic              pattern_done
);

    localparam int unsigned CNT_MAX = (MAX_DOT_CHARS > RANGE_MAX_CHARS) ?
                                      MAX_DOT_CHARS : RANGE_MAX_CHARS;
    localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);
    localparam logic [CHAR_W-1:0] DOT_CLAMP = CHAR_W'(MAX_DOT_CHARS - 1);
    localparam logic [CNT_W-1:0]  DOT_MAXC  = CNT_W'(MAX_DOT_CHARS);

    logic [CHAR_W-1:0] dot_first_reg;
    logic [CHAR_W-1:0] dot_end_reg;
    scan_mode_t        mode_reg;
    scan_mode_t        mode_next;
    logic [CHAR_W-1:0] rs_reg;
    logic [CHAR_W-1:0] rs_next;

    plan_flags_t       plan_reg;
    plan_flags_t       dec;
    logic [CHAR_W-1:0] pre0_char_reg;
    logic [CHAR_W-1:0] pre0_char_next;
    logic [CHAR_W-1:0] post_char_reg;
    logic [CHAR_W-1:0] post_char_next;
    logic [CHAR_W-1:0] run_cur_reg;
    logic [CHAR_W-1:0] run_cur_next;
    logic [CNT_W-1:0]  run_cnt_reg;
    logic [CNT_W-1:0]  run_cnt_next;
    logic              run_up_reg;
    logic              run_up_next;
    logic              fin_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              run_done_reg;
    logic              pattern_done_reg;
    logic [CHAR_W-1:0] emit_char;

    logic              c_upper;
    logic              c_lower;
    logic              c_digit;
    scan_mode_t        cls_mode;
    logic              cls_emit;
    logic              kind_ok;
    logic [CHAR_W-1:0] range_diff;
    logic [CHAR_W-1:0] dot_diff;
    logic              out_free;

    assign c_upper = in_char inside {[CH_UP_A:CH_UP_Z]};
    assign c_lower = in_char inside {[CH_LO_A:CH_LO_Z]};
    assign c_digit = in_char inside {[CH_DIG_0:CH_DIG_9]};

    always_comb
    begin
        cls_mode = MODE_CLASS;
        cls_emit = 1'b1;
        if (in_char == CH_RBRACK)
        begin
            cls_mode = MODE_OUT;
        end
        else if (c_upper)
        begin
            cls_mode = MODE_UP_START;
            cls_emit = 1'b0;
        end
        else if (c_lower)
        begin
            cls_mode = MODE_LO_START;
            cls_emit = 1'b0;
        end
        else if (c_digit)
        begin
            cls_mode = MODE_DG_START;
            cls_emit = 1'b0;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_UP_DASH: kind_ok = c_upper;
            MODE_LO_DASH: kind_ok = c_lower;
            default:      kind_ok = c_digit;
        endcase
    end

    assign range_diff = (in_char >= rs_reg) ? (in_char - rs_reg) : (rs_reg - in_char);
    assign dot_diff   = dot_end_reg - dot_first_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        rs_next        = rs_reg;
        dec            = '0;
        pre0_char_next = CH_LBRACK;
        post_char_next = in_char;
        run_cur_next   = dot_first_reg;
        run_cnt_next   = '0;
        run_up_next    = 1'b1;
        case (mode_reg)
            MODE_CLASS:
            begin
                mode_next = cls_mode;
                dec.post  = cls_emit;
                if (!cls_emit)
                begin
                    rs_next = in_char;
                end
            end
            MODE_UP_START, MODE_LO_START, MODE_DG_START:
            begin
                if (in_char == CH_DASH)
                begin
                    case (mode_reg)
                        MODE_UP_START: mode_next = MODE_UP_DASH;
                        MODE_LO_START: mode_next = MODE_LO_DASH;
                        default:       mode_next = MODE_DG_DASH;
                    endcase
                end
                else
                begin
                    dec.pre0       = 1'b1;
                    pre0_char_next = rs_reg;
                    mode_next      = cls_mode;
                    dec.post       = cls_emit;
                    if (!cls_emit)
                    begin
                        rs_next = in_char;
                    end
                end
            end
            MODE_UP_DASH, MODE_LO_DASH, MODE_DG_DASH:
            begin
                if (kind_ok)
                begin
                    dec.run      = 1'b1;
                    run_cur_next = rs_reg;
                    run_up_next  = (in_char >= rs_reg);
                    run_cnt_next = CNT_W'(range_diff) + CNT_W'(1);
                    mode_next    = MODE_CLASS;
                end
                else
                begin
                    dec.pre0       = 1'b1;
                    pre0_char_next = rs_reg;
                    dec.pre1       = 1'b1;
                    mode_next      = cls_mode;
                    dec.post       = cls_emit;
                    if (!cls_emit)
                    begin
                        rs_next = in_char;
                    end
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_OUT;
                dec.post  = 1'b1;
            end
            default:
            begin
                mode_next = MODE_OUT;
                dec.post  = 1'b1;
                if (in_char == CH_LBRACK)
                begin
                    mode_next = MODE_CLASS;
                end
                else if (in_char == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_char == CH_DOT)
                begin
                    dec.pre0       = 1'b1;
                    post_char_next = CH_RBRACK;
                    if (dot_end_reg >= dot_first_reg)
                    begin
                        dec.run = 1'b1;
                        if (dot_diff >= DOT_CLAMP)
                        begin
                            run_cnt_next = DOT_MAXC;
                        end
                        else
                        begin
                            run_cnt_next = CNT_W'(dot_diff) + CNT_W'(1);
                        end
                    end
                end
            end
        endcase

        if (is_final)
        begin
            if (mode_next == MODE_UP_START || mode_next == MODE_LO_START ||
                mode_next == MODE_DG_START)
            begin
                dec.post       = 1'b1;
                post_char_next = rs_next;
            end
            else if (mode_next == MODE_UP_DASH || mode_next == MODE_LO_DASH ||
                     mode_next == MODE_DG_DASH)
            begin
                dec.pre0       = 1'b1;
                pre0_char_next = rs_reg;
                dec.pre1       = 1'b1;
            end
            mode_next = MODE_OUT;
            rs_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_first_reg <= DOT_FIRST_RESET;
            dot_end_reg   <= DOT_END_RESET;
            mode_reg      <= MODE_OUT;
            rs_reg        <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DOT_FIRST)
            begin
                dot_first_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_DOT_END)
            begin
                dot_end_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                mode_reg <= mode_next;
                rs_reg   <= rs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            plan_reg      <= dec;
            pre0_char_reg <= pre0_char_next;
            post_char_reg <= post_char_next;
            run_cur_reg   <= run_cur_next;
            run_cnt_reg   <= run_cnt_next;
            run_up_reg    <= run_up_next;
            fin_reg       <= is_final;
        end
        else if (cmd.run_step)
        begin
            run_cur_reg <= run_up_reg ? run_cur_reg + CHAR_W'(1) : run_cur_reg - CHAR_W'(1);
            run_cnt_reg <= run_cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_PRE0: emit_char = pre0_char_reg;
            SEL_PRE1: emit_char = CH_DASH;
            SEL_RUN:  emit_char = run_cur_reg;
            default:  emit_char = post_char_reg;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_char_reg     <= emit_char;
            run_done_reg     <= cmd.last;
            pattern_done_reg <= cmd.last && fin_reg;
        end
    end

    assign sts.dec      = dec;
    assign sts.plan     = plan_reg;
    assign sts.run_last = (run_cnt_reg == CNT_W'(1));
    assign sts.run_nz   = (run_cnt_reg != '0);
    assign sts.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign run_done     = run_done_reg;
    assign pattern_done = pattern_done_reg;

    a_final_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_final) |=> (mode_reg == MODE_OUT && rs_reg == '0))
        else $error("scan state not cleared after last pattern character");

    a_pattern_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pattern_done_reg) |-> run_done_reg)
        else $error("pattern end flagged on a result that does not end its run");

endmodule

FILE: rtl/regex_char_class_range_expander_top.sv
// Rewrites a regular expression one character at a time, expanding class ranges such as
// a-z or 9-0 into every character they cover and a dot outside a class into a bracketed
// run dot_first..dot_end, clamped to MAX_DOT_CHARS characters. A pattern character is
// taken only while the block is idle; its results then leave through the output register
// one per cycle whenever that register is free. A dot yields up to MAX_DOT_CHARS + 2
// results and a range up to 26. The single emit sequencer steps one result per cycle
// unless the output stalls; the next character is taken while the last result still
// waits in the output register. Write dot_first and dot_end only while the block is idle.
module regex_char_class_range_expander_top
    import rcx_pkg::*;
#(
    parameter int unsigned MAX_DOT_CHARS = MAX_DOT_CHARS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    rcx_in_if.sink            pattern,
    rcx_out_if.source         result,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CHAR_W-1:0] cfg_data
);

    rcx_cmd_t cmd;
    rcx_sts_t sts;

    rcx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pattern.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcx_datapath #(
        .MAX_DOT_CHARS (MAX_DOT_CHARS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_char      (pattern.in_char),
        .is_final     (pattern.is_final),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_char     (result.out_char),
        .run_done     (result.run_done),
        .pattern_done (result.pattern_done)
    );

    assign pattern.ready = cmd.in_ready;

endmodule
